/* rtl/core/mide_pkg.sv */
// Shared constants, types and helpers for the multi-input debouncer with event queue.
`timescale 1ns / 1ps
`default_nettype none
package mide_pkg;

    localparam int CHANNELS   = 16;
    localparam int RING_DEPTH = 32;
    localparam int COUNT_BITS = 16;

    localparam int CH_W     = $clog2(CHANNELS);
    localparam int NCH_W    = $clog2(CHANNELS + 1);
    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int ENTRY_W  = CH_W + 1;
    localparam int THR_W    = 15;
    localparam int PERIOD_W = 16;
    localparam int CIU_W    = 5;
    localparam int PIN_W    = 16;
    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 3;

    // item modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INACTIVE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DECIDE   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CHANNELS = 3'd5;

    // register reset values
    localparam logic [THR_W-1:0]    RST_ACTIVE   = 15'd20;
    localparam logic [THR_W-1:0]    RST_MARGIN   = 15'd10;
    localparam logic [THR_W-1:0]    RST_INACTIVE = 15'd10;
    localparam logic [PERIOD_W-1:0] RST_SAMPLE   = 16'd1;
    localparam logic [PERIOD_W-1:0] RST_DECIDE   = 16'd1;
    localparam logic [CIU_W-1:0]    RST_CHANNELS = 5'd16;

    localparam logic [COUNT_BITS-1:0] COUNT_DEC = COUNT_BITS'(5);

    typedef logic [COUNT_BITS-1:0] count_t;

    // per-step command to the channel unit
    typedef struct packed {
        logic            step;
        logic            flush;
        logic            do_sample;
        logic            do_decide;
        logic [CH_W-1:0] idx;
        logic            pin;
    } chan_ctrl_t;

    // event produced by one channel step
    typedef struct packed {
        logic            push;
        logic [CH_W-1:0] ch;
        logic            up;
    } chan_event_t;

    // command to the event ring
    typedef struct packed {
        logic            push;
        logic [CH_W-1:0] ch;
        logic            up;
        logic            rd;
        logic            take;
        logic            flush;
    } ring_ctrl_t;

    // counter ceiling, clamped to the largest counter value
    function automatic count_t ceiling(input logic [THR_W-1:0] act,
                                       input logic [THR_W-1:0] margin);
        logic [COUNT_BITS:0] sum;
        logic [COUNT_BITS:0] cmax;
        cmax = (COUNT_BITS + 1)'({COUNT_BITS{1'b1}});
        sum  = (COUNT_BITS + 1)'(act) + (COUNT_BITS + 1)'(margin);
        return (sum > cmax) ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endfunction

    localparam count_t RST_CEILING = ceiling(RST_ACTIVE, RST_MARGIN);

endpackage
`default_nettype wire

/* rtl/core/mide_chan.sv */
// Channel counters and debounced levels with the shared update and compare unit.
`timescale 1ns / 1ps
`default_nettype none
module mide_chan (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mide_pkg::chan_ctrl_t           ctrl,
    input  wire mide_pkg::count_t               ceil_val,
    input  wire logic [mide_pkg::THR_W-1:0]     act_thr,
    input  wire logic [mide_pkg::THR_W-1:0]     inact_thr,
    output mide_pkg::chan_event_t               evt,
    output logic [mide_pkg::CHANNELS-1:0]       levels
);
    import mide_pkg::*;

    count_t                count_reg [CHANNELS];
    logic [CHANNELS-1:0]   level_reg;

    count_t cur_cnt;
    count_t smp_cnt;
    logic   cur_lvl;
    logic   new_lvl;

    // shared unit: sample update then hysteresis decision for one channel
    always_comb
    begin
        cur_cnt = count_reg[ctrl.idx];
        cur_lvl = level_reg[ctrl.idx];
        smp_cnt = cur_cnt;
        if (ctrl.do_sample)
        begin
            if (ctrl.pin)
                smp_cnt = (cur_cnt < ceil_val) ? cur_cnt + 1'b1 : cur_cnt;
            else
                smp_cnt = (cur_cnt > COUNT_DEC) ? cur_cnt - COUNT_DEC : '0;
        end
        new_lvl  = cur_lvl;
        evt.push = 1'b0;
        if (ctrl.do_decide)
        begin
            if (cur_lvl)
            begin
                if (smp_cnt < COUNT_BITS'(inact_thr))
                begin
                    new_lvl  = 1'b0;
                    evt.push = ctrl.step;
                end
            end
            else if (smp_cnt > COUNT_BITS'(act_thr))
            begin
                new_lvl  = 1'b1;
                evt.push = ctrl.step;
            end
        end
        evt.ch = ctrl.idx;
        evt.up = new_lvl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                count_reg[i] <= RST_CEILING;
            level_reg <= '1;
        end
        else if (ctrl.flush)
        begin
            for (int i = 0; i < CHANNELS; i++)
                count_reg[i] <= ceil_val;
            level_reg <= '1;
        end
        else if (ctrl.step)
        begin
            count_reg[ctrl.idx] <= smp_cnt;
            level_reg[ctrl.idx] <= new_lvl;
        end
    end

    assign levels = level_reg;

endmodule
`default_nettype wire

/* rtl/core/mide_ring.sv */
// Event ring: memory with head and tail pointers, oldest entry dropped when full.
`timescale 1ns / 1ps
`default_nettype none
module mide_ring (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mide_pkg::ring_ctrl_t           ctrl,
    output logic [mide_pkg::ENTRY_W-1:0]        rd_data,
    output logic                                empty,
    output logic [mide_pkg::RING_AW-1:0]        pending
);
    import mide_pkg::*;

    localparam logic [RING_AW-1:0] LAST = RING_AW'(RING_DEPTH - 1);

    logic [ENTRY_W-1:0] mem [RING_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [RING_AW-1:0] head_reg, head_next;
    logic [RING_AW-1:0] tail_reg, tail_next;
    logic [RING_AW-1:0] head_inc, tail_inc;

    assign head_inc = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctrl.flush)
        begin
            head_next = '0;
            tail_next = '0;
        end
        else if (ctrl.push)
        begin
            head_next = head_inc;
            // full: drop the oldest entry
            if (head_inc == tail_reg)
                tail_next = tail_inc;
        end
        else if (ctrl.take)
            tail_next = tail_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem[head_reg] <= {ctrl.ch, ctrl.up};
        if (ctrl.rd)
            rd_data_reg <= mem[tail_reg];
    end

    assign rd_data = rd_data_reg;
    assign empty   = (head_reg == tail_reg);
    assign pending = (head_reg >= tail_reg) ? head_reg - tail_reg
                   : RING_AW'(RING_DEPTH) + head_reg - tail_reg;

endmodule
`default_nettype wire

/* rtl/core/multi_input_debouncer_event_queue.sv */
// Top level: register port, period timers, channel sequencer and result register.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------------
//  input     | in_valid / in_stall     | mode, pin_levels
//  output    | out_valid / out_stall   | event_valid, event_channel, event_is_up,
//            |                         | debounced_levels, events_pending
//  config    | psel/penable/pwrite     | paddr, pwdata, prdata, pready (always high)
//
// A tick item scans the N channels in use: the shared counter/compare unit visits one
// channel a cycle. A tick with nothing due or no channel in use skips the scan; a pop
// reads and then takes the oldest entry (neither on an empty ring); a flush or unused
// mode goes straight to the result.
// Reset (rst_n, asynchronous) loads register defaults, reloads every counter to the
// ceiling, sets every level high and empties the ring. A stalled result is held in the
// output register; the next item is accepted meanwhile and waits only to load its result.
`timescale 1ns / 1ps
`default_nettype none
module multi_input_debouncer_event_queue (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input items
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [mide_pkg::MODE_W-1:0]      mode,
    input  wire logic [mide_pkg::PIN_W-1:0]       pin_levels,
    // result items
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  event_valid,
    output logic [mide_pkg::CH_W-1:0]             event_channel,
    output logic                                  event_is_up,
    output logic [mide_pkg::CHANNELS-1:0]         debounced_levels,
    output logic [mide_pkg::RING_AW-1:0]          events_pending,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mide_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [mide_pkg::DATA_W-1:0]      pwdata,
    output logic [mide_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);
    import mide_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHAN     = 3'd1;
    localparam logic [2:0] S_POP_RD   = 3'd2;
    localparam logic [2:0] S_POP_TAKE = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    // ---------------- configuration registers ----------------
    logic [THR_W-1:0]    act_reg;
    logic [THR_W-1:0]    margin_reg;
    logic [THR_W-1:0]    inact_reg;
    logic [PERIOD_W-1:0] sample_per_reg;
    logic [PERIOD_W-1:0] decide_per_reg;
    logic [CIU_W-1:0]    ciu_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg        <= RST_ACTIVE;
            margin_reg     <= RST_MARGIN;
            inact_reg      <= RST_INACTIVE;
            sample_per_reg <= RST_SAMPLE;
            decide_per_reg <= RST_DECIDE;
            ciu_reg        <= RST_CHANNELS;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ACTIVE:   act_reg        <= pwdata[THR_W-1:0];
                REG_MARGIN:   margin_reg     <= pwdata[THR_W-1:0];
                REG_INACTIVE: inact_reg      <= pwdata[THR_W-1:0];
                REG_SAMPLE:   sample_per_reg <= pwdata[PERIOD_W-1:0];
                REG_DECIDE:   decide_per_reg <= pwdata[PERIOD_W-1:0];
                REG_CHANNELS: ciu_reg        <= pwdata[CIU_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ACTIVE:   prdata = DATA_W'(act_reg);
            REG_MARGIN:   prdata = DATA_W'(margin_reg);
            REG_INACTIVE: prdata = DATA_W'(inact_reg);
            REG_SAMPLE:   prdata = DATA_W'(sample_per_reg);
            REG_DECIDE:   prdata = DATA_W'(decide_per_reg);
            REG_CHANNELS: prdata = DATA_W'(ciu_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- derived configuration ----------------
    count_t           ceil_val;
    logic [NCH_W-1:0] n_chan;
    logic [CHANNELS-1:0] chan_mask;

    assign ceil_val = ceiling(act_reg, margin_reg);
    // clamp channels in use to the channels built
    assign n_chan = (NCH_W'(ciu_reg) > NCH_W'(CHANNELS)) ? NCH_W'(CHANNELS) : NCH_W'(ciu_reg);

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
            chan_mask[i] = (NCH_W'(i) < n_chan);
    end

    // ---------------- sequencer ----------------
    logic [2:0]          state_reg, state_next;
    logic [CH_W-1:0]     idx_reg, idx_next;
    logic [PIN_W-1:0]    pins_reg;
    logic                do_sample_reg, do_decide_reg;
    logic [PERIOD_W-1:0] stimer_reg, stimer_next;
    logic [PERIOD_W-1:0] dtimer_reg, dtimer_next;
    logic                ev_valid_reg, ev_up_reg;
    logic [CH_W-1:0]     ev_ch_reg;

    logic                in_accept;
    logic                s_elapsed, d_elapsed, d_enable;
    logic [PERIOD_W-1:0] s_inc, d_inc, s_per, d_per;
    logic                last_chan;
    logic                out_load;

    chan_ctrl_t          chan_ctrl;
    chan_event_t         chan_evt;
    ring_ctrl_t          ring_ctrl;
    logic [CHANNELS-1:0] levels;
    logic [ENTRY_W-1:0]  ring_rd;
    logic                ring_empty;
    logic [RING_AW-1:0]  ring_pending;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // timers advance once per tick; a zero period acts as one
    assign s_per     = (sample_per_reg == '0) ? PERIOD_W'(1) : sample_per_reg;
    assign d_per     = (decide_per_reg == '0) ? PERIOD_W'(1) : decide_per_reg;
    assign s_inc     = stimer_reg + 1'b1;
    assign d_inc     = dtimer_reg + 1'b1;
    assign s_elapsed = (s_inc >= s_per);
    assign d_elapsed = (d_inc >= d_per);
    assign d_enable  = d_elapsed && (act_reg != '0);
    assign last_chan = (NCH_W'(idx_reg) == n_chan - 1'b1);
    assign out_load  = (state_reg == S_DONE) && (!out_valid || !out_stall);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        stimer_next = stimer_reg;
        dtimer_next = dtimer_reg;
        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (in_accept)
                begin
                    case (mode)
                        MODE_TICK:
                        begin
                            stimer_next = s_elapsed ? '0 : s_inc;
                            dtimer_next = d_elapsed ? '0 : d_inc;
                            // skip the scan when nothing is due or no channel is in use
                            if ((s_elapsed || d_enable) && (n_chan != '0))
                                state_next = S_CHAN;
                            else
                                state_next = S_DONE;
                        end
                        MODE_POP:
                            state_next = ring_empty ? S_DONE : S_POP_RD;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_CHAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (last_chan)
                    state_next = S_DONE;
            end
            S_POP_RD:   state_next = S_POP_TAKE;
            S_POP_TAKE: state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            stimer_reg    <= '0;
            dtimer_reg    <= '0;
            do_sample_reg <= 1'b0;
            do_decide_reg <= 1'b0;
            ev_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            stimer_reg <= stimer_next;
            dtimer_reg <= dtimer_next;
            if (in_accept)
            begin
                do_sample_reg <= (mode == MODE_TICK) && s_elapsed;
                do_decide_reg <= (mode == MODE_TICK) && d_enable;
                ev_valid_reg  <= 1'b0;
            end
            else if (state_reg == S_POP_TAKE)
                ev_valid_reg <= 1'b1;
        end
    end

    // payload of the item under work
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pins_reg  <= pin_levels;
            ev_ch_reg <= '0;
            ev_up_reg <= 1'b0;
        end
        else if (state_reg == S_POP_TAKE)
        begin
            ev_ch_reg <= ring_rd[ENTRY_W-1:1];
            ev_up_reg <= ring_rd[0];
        end
    end

    // ---------------- channel unit and ring ----------------
    always_comb
    begin
        chan_ctrl.step      = (state_reg == S_CHAN);
        chan_ctrl.flush     = in_accept && (mode == MODE_FLUSH);
        chan_ctrl.do_sample = do_sample_reg;
        chan_ctrl.do_decide = do_decide_reg;
        chan_ctrl.idx       = idx_reg;
        // channels past the pin field read low
        chan_ctrl.pin       = (32'(idx_reg) < PIN_W) ? pins_reg[idx_reg] : 1'b0;

        ring_ctrl.push  = chan_evt.push;
        ring_ctrl.ch    = chan_evt.ch;
        ring_ctrl.up    = chan_evt.up;
        ring_ctrl.rd    = (state_reg == S_POP_RD);
        ring_ctrl.take  = (state_reg == S_POP_TAKE);
        ring_ctrl.flush = chan_ctrl.flush;
    end

    mide_chan u_chan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (chan_ctrl),
        .ceil_val  (ceil_val),
        .act_thr   (act_reg),
        .inact_thr (inact_reg),
        .evt       (chan_evt),
        .levels    (levels)
    );

    mide_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ring_ctrl),
        .rd_data (ring_rd),
        .empty   (ring_empty),
        .pending (ring_pending)
    );

    // ---------------- result register ----------------
    logic                out_valid_reg;
    logic                res_valid_reg, res_up_reg;
    logic [CH_W-1:0]     res_ch_reg;
    logic [CHANNELS-1:0] res_levels_reg;
    logic [RING_AW-1:0]  res_pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_valid_reg   <= ev_valid_reg;
            res_ch_reg      <= ev_ch_reg;
            res_up_reg      <= ev_up_reg;
            res_levels_reg  <= levels & chan_mask;
            res_pending_reg <= ring_pending;
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_valid      = res_valid_reg;
    assign event_channel    = res_ch_reg;
    assign event_is_up      = res_up_reg;
    assign debounced_levels = res_levels_reg;
    assign events_pending   = res_pending_reg;

    // ---------------- assertions ----------------
    a_pop_empty_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (mode == MODE_POP) && ring_empty) |=> (state_reg == S_DONE))
        else $error("pop on empty ring did not finish at once");

    a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHAN) |-> (do_sample_reg || do_decide_reg))
        else $error("channel scan started with nothing due");

    a_push_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
        ring_ctrl.push |-> ((state_reg == S_CHAN) && do_decide_reg))
        else $error("event pushed outside a decision scan");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && !out_valid_reg) |=> out_valid_reg)
        else $error("finished item did not reach the result register");

endmodule
`default_nettype wire

/* tb/multi_input_debouncer_event_queue_tb.sv */
// Self-checking testbench for the multi-input debouncer with event queue.
`timescale 1ns / 1ps
module multi_input_debouncer_event_queue_tb;

    import mide_pkg::*;

    // Mode 3 has no name in the package; it must leave all state alone.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // Idling profiles of the two handshakes.
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 40;

    // One result item as it leaves the block.
    typedef struct packed {
        logic                ev_valid;
        logic [CH_W-1:0]     ev_ch;
        logic                ev_up;
        logic [CHANNELS-1:0] levels;
        logic [RING_AW-1:0]  pending;
    } debounce_result_t;

    // Register settings of one phase of the run, with its stimulus profile.
    typedef struct {
        logic [THR_W-1:0]    act;
        logic [THR_W-1:0]    margin;
        logic [THR_W-1:0]    inact;
        logic [PERIOD_W-1:0] samp;
        logic [PERIOD_W-1:0] dec;
        logic [CIU_W-1:0]    chans;
        int                  items;
        int                  idle;
        bit                  pressure;
    } run_phase_t;

    // Tracks the debouncer state, predicts each result and checks what comes out.
    class debounce_tracker;
        logic [THR_W-1:0]    act_thr;
        logic [THR_W-1:0]    margin;
        logic [THR_W-1:0]    inact_thr;
        logic [PERIOD_W-1:0] sample_per;
        logic [PERIOD_W-1:0] decide_per;
        logic [CIU_W-1:0]    chans;
        count_t              counts [CHANNELS];
        logic                levels [CHANNELS];
        logic [ENTRY_W-1:0]  ring [RING_DEPTH];
        int unsigned         head;
        int unsigned         tail;
        logic [PERIOD_W-1:0] sample_tmr;
        logic [PERIOD_W-1:0] decide_tmr;
        debounce_result_t    due_results [$];
        int                  bad_results;
        int                  seen;

        function new();
            act_thr    = RST_ACTIVE;
            margin     = RST_MARGIN;
            inact_thr  = RST_INACTIVE;
            sample_per = RST_SAMPLE;
            decide_per = RST_DECIDE;
            chans      = RST_CHANNELS;
            sample_tmr = '0;
            decide_tmr = '0;
            bad_results = 0;
            seen = 0;
            refill();
        endfunction

        function count_t count_ceiling();
            logic [COUNT_BITS:0] sum;
            sum = {2'b00, act_thr} + {2'b00, margin};
            return (sum > {1'b0, {COUNT_BITS{1'b1}}}) ? {COUNT_BITS{1'b1}}
                                                        : sum[COUNT_BITS-1:0];
        endfunction

        function int live_channels();
            return (chans > CHANNELS) ? CHANNELS : int'(chans);
        endfunction

        // Empty the ring, reload every counter, set every level high.
        function void refill();
            count_t c;
            c = count_ceiling();
            head = 0;
            tail = 0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                counts[i] = c;
                levels[i] = 1'b1;
            end
        endfunction

        function bit period_elapsed(inout logic [PERIOD_W-1:0] tmr,
                                    input logic [PERIOD_W-1:0] per);
            logic [PERIOD_W-1:0] p;
            p = (per == '0) ? PERIOD_W'(1) : per;
            tmr = tmr + 1'b1;
            if (tmr >= p)
            begin
                tmr = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Push an event; a full ring drops its oldest entry.
        function void push_event(int ch, logic up);
            ring[head] = {ch[CH_W-1:0], up};
            head = (head + 1) % RING_DEPTH;
            if (head == tail)
                tail = (tail + 1) % RING_DEPTH;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_ACTIVE:   act_thr    = value[THR_W-1:0];
                REG_MARGIN:   margin     = value[THR_W-1:0];
                REG_INACTIVE: inact_thr  = value[THR_W-1:0];
                REG_SAMPLE:   sample_per = value[PERIOD_W-1:0];
                REG_DECIDE:   decide_per = value[PERIOD_W-1:0];
                REG_CHANNELS: chans      = value[CIU_W-1:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted item and queue the result it must produce.
        function void accept_item(logic [MODE_W-1:0] mode, logic [PIN_W-1:0] pins);
            debounce_result_t r;
            bit do_sample;
            bit do_decide;
            int n;
            count_t c;
            logic [ENTRY_W-1:0] e;
            r = '0;
            n = live_channels();
            c = count_ceiling();
            case (mode)
                MODE_TICK:
                begin
                    do_sample = period_elapsed(sample_tmr, sample_per);
                    do_decide = period_elapsed(decide_tmr, decide_per);
                    if (do_sample)
                        for (int i = 0; i < n; i++)
                        begin
                            if (pins[i])
                            begin
                                if (counts[i] < c)
                                    counts[i] = counts[i] + 1'b1;
                            end
                            else if (counts[i] > COUNT_DEC)
                                counts[i] = counts[i] - COUNT_DEC;
                            else
                                counts[i] = '0;
                        end
                    if (do_decide && act_thr != 0)
                        for (int i = 0; i < n; i++)
                        begin
                            if (levels[i])
                            begin
                                if (counts[i] < inact_thr)
                                begin
                                    push_event(i, 1'b0);
                                    levels[i] = 1'b0;
                                end
                            end
                            else if (counts[i] > act_thr)
                            begin
                                push_event(i, 1'b1);
                                levels[i] = 1'b1;
                            end
                        end
                end
                MODE_POP:
                    if (head != tail)
                    begin
                        e = ring[tail];
                        tail = (tail + 1) % RING_DEPTH;
                        r.ev_valid = 1'b1;
                        r.ev_ch    = e[ENTRY_W-1:1];
                        r.ev_up    = e[0];
                    end
                MODE_FLUSH:
                    refill();
                default: ;
            endcase
            for (int i = 0; i < n; i++)
                r.levels[i] = levels[i];
            r.pending = RING_AW'((head + RING_DEPTH - tail) % RING_DEPTH);
            due_results.push_back(r);
        endfunction

        function void check_result(debounce_result_t got);
            debounce_result_t want;
            seen++;
            if (due_results.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("result %0d arrived with nothing expected: %p", seen, got);
                return;
            end
            want = due_results.pop_front();
            if (want.ev_valid !== got.ev_valid || want.ev_ch !== got.ev_ch
                || want.ev_up !== got.ev_up || want.levels !== got.levels
                || want.pending !== got.pending)
            begin
                bad_results++;
                if (bad_results <= 10)
                begin
                    $display("result %0d mismatch (expected/actual): valid %0d/%0d ch %0d/%0d",
                             seen, want.ev_valid, got.ev_valid, want.ev_ch, got.ev_ch);
                    $display("    up %0d/%0d levels %h/%h pending %0d/%0d",
                             want.ev_up, got.ev_up, want.levels, got.levels,
                             want.pending, got.pending);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [MODE_W-1:0]   mode;
    logic [PIN_W-1:0]    pin_levels;
    logic                out_valid;
    logic                out_stall;
    logic                event_valid;
    logic [CH_W-1:0]     event_channel;
    logic                event_is_up;
    logic [CHANNELS-1:0] debounced_levels;
    logic [RING_AW-1:0]  events_pending;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    debounce_tracker     tracker = new();
    int                  idle_mode = IDLE_NONE;
    bit                  hold_request = 1'b0;
    int                  hold_left = 0;
    logic [PIN_W-1:0]    pin_hold = '0;
    run_phase_t          phases [8];

    multi_input_debouncer_event_queue dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .pin_levels       (pin_levels),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_valid      (event_valid),
        .event_channel    (event_channel),
        .event_is_up      (event_is_up),
        .debounced_levels (debounced_levels),
        .events_pending   (events_pending),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #1 clk = ~clk;

    // Hard stop in case the block hangs somewhere.
    initial
    begin
        #2_000_000;
        $display("multi_input_debouncer_event_queue_tb: errors");
        $finish;
    end

    function bit sender_gap();
        if (idle_mode == IDLE_SENDER)
            return $urandom_range(99) < 71;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 12;
        return 1'b0;
    endfunction

    function bit receiver_gap();
        if (idle_mode == IDLE_RECEIVER)
            return $urandom_range(99) < 71;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 12;
        return 1'b0;
    endfunction

    // Pin levels that look like real switches: each pin holds a level for a
    // stretch and flips now and then, with short bounces on top. A few ticks
    // carry plain noise instead.
    function logic [PIN_W-1:0] next_pins();
        logic [PIN_W-1:0] bounce;
        bounce = '0;
        if ($urandom_range(19) == 0)
            return PIN_W'($urandom);
        for (int i = 0; i < PIN_W; i++)
        begin
            if ($urandom_range(29) == 0)
                pin_hold[i] = ~pin_hold[i];
            bounce[i] = ($urandom_range(15) == 0);
        end
        return pin_hold ^ bounce;
    endfunction

    // Receiver: check every accepted result, then pick the stall for the next cycle.
    // A requested hold-off keeps stall high for a long stretch so the block backs up.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result({event_valid, event_channel, event_is_up,
                                  debounced_levels, events_pending});
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= receiver_gap();
    end

    // Offer one item, hold it until accepted, then note it in the tracker.
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [PIN_W-1:0] p);
        while (sender_gap())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        pin_levels <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.accept_item(m, p);
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 72)
            send_item(MODE_TICK, next_pins());
        else if (pick < 92)
            send_item(MODE_POP, PIN_W'($urandom));
        else if (pick < 97)
            send_item(MODE_FLUSH, PIN_W'($urandom));
        else
            send_item(MODE_SPARE, PIN_W'($urandom));
    endtask

    // Drop valid and wait until every expected result is out, then let the
    // block settle before anything touches the registers.
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup and access cycle; psel stays high across back-to-back writes.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_reg(idx, value);
    endtask

    task automatic program_regs(input run_phase_t ph);
        write_reg(REG_ACTIVE,   DATA_W'(ph.act));
        write_reg(REG_MARGIN,   DATA_W'(ph.margin));
        write_reg(REG_INACTIVE, DATA_W'(ph.inact));
        write_reg(REG_SAMPLE,   DATA_W'(ph.samp));
        write_reg(REG_DECIDE,   DATA_W'(ph.dec));
        write_reg(REG_CHANNELS, DATA_W'(ph.chans));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_TICK;
        pin_levels = '0;
        out_stall  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        // Defaults, then fast thresholds that overflow the ring, a phase with
        // decisions switched off, the register extremes, zero channels, an odd
        // channel count, a single slow channel and a moderate mix.
        phases[0] = '{15'd20,    15'd10,    15'd10,    16'd1,     16'd1,     5'd16,
                      120, IDLE_SENDER,   1'b0};
        phases[1] = '{15'd1,     15'd1,     15'd1,     16'd1,     16'd1,     5'd16,
                      120, IDLE_RECEIVER, 1'b1};
        phases[2] = '{15'd0,     15'd32767, 15'd32767, 16'd2,     16'd3,     5'd5,
                      60,  IDLE_BOTH,     1'b0};
        phases[3] = '{15'd32767, 15'd32767, 15'd32767, 16'd0,     16'd0,     5'd31,
                      60,  IDLE_NONE,     1'b0};
        phases[4] = '{15'd5,     15'd5,     15'd5,     16'd0,     16'd0,     5'd0,
                      20,  IDLE_NONE,     1'b0};
        phases[5] = '{15'd4,     15'd3,     15'd2,     16'd1,     16'd2,     5'd9,
                      150, IDLE_BOTH,     1'b1};
        phases[6] = '{15'd32767, 15'd0,     15'd0,     16'd65535, 16'd65535, 5'd1,
                      30,  IDLE_SENDER,   1'b0};
        phases[7] = '{15'd3,     15'd2,     15'd2,     16'd1,     16'd1,     5'd16,
                      150, IDLE_RECEIVER, 1'b0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at reset settings.
        send_item(MODE_POP, 16'h0000);           // pop on an empty ring
        send_item(MODE_SPARE, 16'hFFFF);         // unused mode reports status only
        send_item(MODE_TICK, 16'hFFFF);          // counters already at the ceiling
        repeat (5) send_item(MODE_TICK, 16'h0000); // every channel falls, 16 down events
        repeat (3) send_item(MODE_POP, 16'h0000);
        send_item(MODE_TICK, 16'hA5A5);
        send_item(MODE_TICK, 16'h5A5A);
        send_item(MODE_FLUSH, 16'h0000);         // ring emptied, levels high again
        send_item(MODE_POP, 16'hFFFF);           // nothing left after the flush
        send_item(MODE_TICK, 16'h8001);

        // Phases run without a flush in between, so counters left above a
        // lowered ceiling get exercised too.
        foreach (phases[k])
        begin
            drain();
            program_regs(phases[k]);
            idle_mode = phases[k].idle;
            if (phases[k].pressure)
                hold_request = 1'b1;
            repeat (phases[k].items) send_random_item();
        end

        drain();
        if (tracker.bad_results == 0 && tracker.due_results.size() == 0)
            $display("multi_input_debouncer_event_queue_tb: clean");
        else
            $display("multi_input_debouncer_event_queue_tb: errors");
        $finish;
    end

endmodule

/* files.f */
rtl/core/mide_pkg.sv
rtl/core/mide_chan.sv
rtl/core/mide_ring.sv
rtl/core/multi_input_debouncer_event_queue.sv
tb/multi_input_debouncer_event_queue_tb.sv
